/* design/mma_pkg.sv */
// mma_pkg: shared constants, command and configuration types for the
// multichannel moving average unit. No dependencies.
`timescale 1ns / 1ps

package mma_pkg;

  localparam int WINDOW_LEN   = 16;
  localparam int NUM_CHANNELS = 8;

  localparam int SAMPLE_W  = 16;
  localparam int IN_CH_W   = 4;
  localparam int OUT_CH_W  = 3;
  localparam int AVG_W     = 15;
  localparam int MASK_W    = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 15;

  localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int POS_W  = $clog2(WINDOW_LEN);
  localparam int ADDR_W = CH_W + POS_W;
  localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW_LEN);
  localparam int MAG_W  = SUM_W - 1;
  localparam int RCP_K  = SUM_W + 7;
  localparam int PROD_W = MAG_W + RCP_K;
  localparam logic [RCP_K-1:0] RECIP = RCP_K'((64'd1 << RCP_K) / WINDOW_LEN);

  localparam logic [CFG_IDX_W-1:0] REG_VOLT_MASK = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SYS_ADC   = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    OP_SAMPLE,
    OP_TICK,
    OP_BAD
  } op_e;

  typedef struct packed {
    op_e                 op;
    logic [CH_W-1:0]     ch;
    logic [SAMPLE_W-1:0] sample;
  } cmd_t;

  typedef struct packed {
    logic [MASK_W-1:0] volt_mask;
    logic [AVG_W-1:0]  sys_adc;
  } cfg_t;

endpackage

/* design/mma_front.sv */
// mma_front: accepts input items and classifies them as sample, tick or bad
// channel commands. Depends on mma_pkg.
`timescale 1ns / 1ps

module mma_front (
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         mode_i,
  input  logic [mma_pkg::IN_CH_W-1:0]  channel_i,
  input  logic [mma_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                         q_full_i,
  output logic                         push_o,
  output mma_pkg::cmd_t                cmd_o
);
  import mma_pkg::*;

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    cmd_o.ch     = channel_i[CH_W-1:0];
    cmd_o.sample = sample_i;
    if (mode_i) begin
      cmd_o.op = OP_TICK;
    end else if (channel_i >= IN_CH_W'(NUM_CHANNELS)) begin
      cmd_o.op = OP_BAD;
    end else begin
      cmd_o.op = OP_SAMPLE;
    end
  end

endmodule

/* design/mma_queue.sv */
// mma_queue: two-entry command queue between front and back end.
// Depends on mma_pkg.
`timescale 1ns / 1ps

module mma_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mma_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output mma_pkg::cmd_t cmd_o
);
  import mma_pkg::*;

  cmd_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign cmd_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

/* design/mma_back.sv */
// mma_back: executes queued commands: sample ring and window sums, tick walk
// with reciprocal divide, and the output register. Depends on mma_pkg.
`timescale 1ns / 1ps

module mma_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  mma_pkg::cfg_t                cfg_i,
  input  logic                         q_empty_i,
  input  mma_pkg::cmd_t                q_cmd_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [mma_pkg::OUT_CH_W-1:0] out_channel_o,
  output logic [mma_pkg::AVG_W-1:0]    average_o,
  output logic                         bad_channel_o,
  output logic                         last_o
);
  import mma_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SUM  = 3'd1;
  localparam logic [2:0] S_T0   = 3'd2;
  localparam logic [2:0] S_T1   = 3'd3;
  localparam logic [2:0] S_T2   = 3'd4;

  localparam logic [POS_W-1:0] POS_MAX = POS_W'(WINDOW_LEN - 1);
  localparam logic [MAG_W-1:0] WLEN    = MAG_W'(WINDOW_LEN);

  logic [2:0] state_q, state_d;

  logic [SAMPLE_W-1:0] ring_mem [2**ADDR_W];
  logic [SAMPLE_W-1:0] rd_q;

  logic signed [SUM_W-1:0] sum_q [NUM_CHANNELS];
  logic [POS_W-1:0]        pos_q [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] wrapped_q;

  logic [CH_W-1:0]     ch_q, ch_d;
  logic [SAMPLE_W-1:0] smp_q, smp_d;
  logic [MAG_W-1:0]    p_q, p_d;
  logic [MAG_W-1:0]    qe_q, qe_d;

  logic                out_valid_q, out_valid_d;
  logic [OUT_CH_W-1:0] out_ch_q, out_ch_d;
  logic [AVG_W-1:0]    avg_q, avg_d;
  logic                bad_q, bad_d;
  logic                last_q, last_d;

  logic                    out_free;
  logic                    rd_en;
  logic [ADDR_W-1:0]       rd_addr;
  logic                    wr_en;
  logic [ADDR_W-1:0]       wr_addr;
  logic [SAMPLE_W-1:0]     old_smp;
  logic signed [SUM_W-1:0] new_sum;
  logic [SUM_W-1:0]        cur_sum;
  logic [PROD_W-1:0]       prod;
  logic [MAG_W-1:0]        qw;
  logic [MAG_W-1:0]        rem;
  logic [MAG_W-1:0]        quo;
  logic [AVG_W:0]          diff;
  logic [AVG_W-1:0]        result;

  assign out_free = !out_valid_q || !out_stall_i;

  assign rd_addr = {q_cmd_i.ch, pos_q[q_cmd_i.ch]};
  assign wr_addr = {ch_q, pos_q[ch_q]};
  assign old_smp = wrapped_q[ch_q] ? rd_q : '0;
  assign new_sum = sum_q[ch_q]
                 - {{(SUM_W-SAMPLE_W){old_smp[SAMPLE_W-1]}}, old_smp}
                 + {{(SUM_W-SAMPLE_W){smp_q[SAMPLE_W-1]}}, smp_q};

  assign cur_sum = sum_q[ch_q];
  assign prod    = PROD_W'(p_q) * PROD_W'(RECIP);
  assign qw      = qe_q * WLEN;
  assign rem     = p_q - qw;
  assign quo     = (rem >= WLEN) ? qe_q + MAG_W'(1) : qe_q;
  assign diff    = {1'b0, cfg_i.sys_adc} - {1'b0, quo[AVG_W-1:0]};

  always_comb begin
    if (cfg_i.volt_mask[3'(ch_q)]) begin
      result = diff[AVG_W] ? '0 : diff[AVG_W-1:0];
    end else begin
      result = quo[AVG_W-1:0];
    end
  end

  always_comb begin
    state_d     = state_q;
    ch_d        = ch_q;
    smp_d       = smp_q;
    p_d         = p_q;
    qe_d        = qe_q;
    pop_o       = 1'b0;
    rd_en       = 1'b0;
    wr_en       = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    out_ch_d    = out_ch_q;
    avg_d       = avg_q;
    bad_d       = bad_q;
    last_d      = last_q;
    case (state_q)
      S_IDLE: begin
        if (!q_empty_i) begin
          case (q_cmd_i.op)
            OP_SAMPLE: begin
              pop_o   = 1'b1;
              rd_en   = 1'b1;
              ch_d    = q_cmd_i.ch;
              smp_d   = q_cmd_i.sample;
              state_d = S_SUM;
            end
            OP_TICK: begin
              pop_o   = 1'b1;
              ch_d    = CH_W'(NUM_CHANNELS - 1);
              state_d = S_T0;
            end
            default: begin
              if (out_free) begin
                pop_o       = 1'b1;
                out_valid_d = 1'b1;
                out_ch_d    = '0;
                avg_d       = '0;
                bad_d       = 1'b1;
                last_d      = 1'b1;
              end
            end
          endcase
        end
      end
      S_SUM: begin
        wr_en   = 1'b1;
        state_d = S_IDLE;
      end
      S_T0: begin
        p_d     = cur_sum[SUM_W-1] ? '0 : cur_sum[MAG_W-1:0];
        state_d = S_T1;
      end
      S_T1: begin
        qe_d    = prod[RCP_K +: MAG_W];
        state_d = S_T2;
      end
      S_T2: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_ch_d    = OUT_CH_W'(ch_q);
          avg_d       = result;
          bad_d       = 1'b0;
          last_d      = (ch_q == '0);
          if (ch_q == '0) begin
            state_d = S_IDLE;
          end else begin
            ch_d    = ch_q - CH_W'(1);
            state_d = S_T0;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      wrapped_q   <= '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        sum_q[i] <= '0;
        pos_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (wr_en) begin
        sum_q[ch_q] <= new_sum;
        if (pos_q[ch_q] == POS_MAX) begin
          pos_q[ch_q]     <= '0;
          wrapped_q[ch_q] <= 1'b1;
        end else begin
          pos_q[ch_q] <= pos_q[ch_q] + POS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q     <= ch_d;
    smp_q    <= smp_d;
    p_q      <= p_d;
    qe_q     <= qe_d;
    out_ch_q <= out_ch_d;
    avg_q    <= avg_d;
    bad_q    <= bad_d;
    last_q   <= last_d;
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q <= ring_mem[rd_addr];
    end
    if (wr_en) begin
      ring_mem[wr_addr] <= smp_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_channel_o = out_ch_q;
  assign average_o     = avg_q;
  assign bad_channel_o = bad_q;
  assign last_o        = last_q;

endmodule

/* design/multichannel_moving_average_unit.sv */
// Channel | Handshake             | Payload
// in      | in_valid_i/in_stall_o | mode_i, channel_i, sample_i
// out     | out_valid_o/out_stall_i | out_channel_o, average_o, bad_channel_o, last_o
// cfg     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// A sample item does a ring read, then a sum update and ring write. A tick
// item walks the channels from the highest down to 0 through sum read,
// reciprocal multiply and correction; correction waits on output stalls.
// A bad-channel item waits for a free output. Reset clears sums, ring positions
// and the ring fill flags; no clearing pass. A two-entry queue decouples input
// acceptance from the back end; output stalls hold the back end in place.
// Depends on mma_pkg, mma_front, mma_queue, mma_back.
`timescale 1ns / 1ps

module multichannel_moving_average_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          mode_i,
  input  logic [mma_pkg::IN_CH_W-1:0]   channel_i,
  input  logic [mma_pkg::SAMPLE_W-1:0]  sample_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [mma_pkg::OUT_CH_W-1:0]  out_channel_o,
  output logic [mma_pkg::AVG_W-1:0]     average_o,
  output logic                          bad_channel_o,
  output logic                          last_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [mma_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [mma_pkg::CFG_W-1:0]     cfg_data_i
);
  import mma_pkg::*;

  cfg_t cfg_q;
  logic push;
  logic pop;
  logic q_full;
  logic q_empty;
  cmd_t cmd_in;
  cmd_t cmd_head;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_VOLT_MASK: cfg_q.volt_mask <= cfg_data_i[MASK_W-1:0];
        REG_SYS_ADC:   cfg_q.sys_adc   <= cfg_data_i[AVG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  mma_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .mode_i     (mode_i),
    .channel_i  (channel_i),
    .sample_i   (sample_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .cmd_o      (cmd_in)
  );

  mma_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd_in),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .cmd_o   (cmd_head)
  );

  mma_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .q_empty_i     (q_empty),
    .q_cmd_i       (cmd_head),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_channel_o (out_channel_o),
    .average_o     (average_o),
    .bad_channel_o (bad_channel_o),
    .last_o        (last_o)
  );

endmodule

/* design/mma_checker.sv */
// mma_checker: port-level assertions for multichannel_moving_average_unit,
// bound to the top level. Depends on mma_pkg.
`timescale 1ns / 1ps

module mma_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [mma_pkg::OUT_CH_W-1:0] out_channel_o,
  input logic [mma_pkg::AVG_W-1:0]    average_o,
  input logic                         bad_channel_o,
  input logic                         last_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_channel_o)
      && $stable(average_o) && $stable(bad_channel_o) && $stable(last_o))
    else $error("stalled output item changed");

  a_bad_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_channel_o |-> last_o && average_o == '0
      && out_channel_o == '0)
    else $error("bad channel item malformed");

  a_last_ch0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !bad_channel_o && out_channel_o == '0 |-> last_o)
    else $error("tick item for channel 0 not marked last");

  a_last_only_ch0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !bad_channel_o && last_o |-> out_channel_o == '0)
    else $error("tick item marked last on nonzero channel");

endmodule

bind multichannel_moving_average_unit mma_checker u_mma_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .out_channel_o (out_channel_o),
  .average_o     (average_o),
  .bad_channel_o (bad_channel_o),
  .last_o        (last_o)
);
